// ===== rtl/vra_pkg.sv =====
`timescale 1ns / 1ps
package vra_pkg;
	localparam int Lanes = 4;
	localparam int MaxSamples = 1024;
	localparam int DataW = 16;
	localparam int SqW = 32;
	localparam int SumW = 45;
	localparam int CntW = 11;
	localparam int RootW = 16;
	localparam int QDepth = 2;

	typedef logic [SqW-1:0] sq_t;
	typedef logic [SumW-1:0] sum_t;
	typedef logic [RootW-1:0] root_t;

	typedef struct packed {
		sq_t [Lanes-1:0] sq;
		logic            cnt_en;
		logic            last;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_SQRT,
		BK_OUT
	} bk_state_t;
endpackage

// ===== rtl/vector_rmse_accumulator_core.sv =====
`timescale 1ns / 1ps
// Per-lane RMSE over sets of estimate/truth pairs. Squares are formed in the
// front and queued; the back accumulates one beat a cycle while idle. A
// last beat starts a restoring divide by the count and then a bit-serial
// root, and the back takes no new beat from the queue until the result has
// been popped; the front stalls once the two-entry queue between them fills.
module vector_rmse_accumulator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic signed [15:0] est_0, est_1, est_2, est_3,
	input  logic signed [15:0] truth_0, truth_1, truth_2, truth_3,
	input  logic        last_pair,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] rmse_0, rmse_1, rmse_2, rmse_3,
	output logic        overflow
);
	logic signed [15:0] est [vra_pkg::Lanes];
	logic signed [15:0] truth [vra_pkg::Lanes];
	vra_pkg::root_t root [vra_pkg::Lanes];
	vra_pkg::job_t fq, bq;
	logic ready, fpush, qfull, qempty, qpop;

	assign est = '{est_0, est_1, est_2, est_3};
	assign truth = '{truth_0, truth_1, truth_2, truth_3};
	assign full = !ready;

	vra_front u_front (.clk, .arst_n, .in_valid(push), .est, .truth, .last_pair,
		.q_full(qfull), .ready, .q_push(fpush), .q_data(fq));
	vra_queue u_queue (.clk, .arst_n, .push(fpush), .wdata(fq), .full(qfull),
		.pop(qpop), .empty(qempty), .rdata(bq));
	vra_back u_back (.clk, .arst_n, .q_empty(qempty), .q_data(bq), .q_pop(qpop),
		.root, .ovf(overflow), .res_empty(empty), .res_pop(pop));

	assign rmse_0 = root[0];
	assign rmse_1 = root[1];
	assign rmse_2 = root[2];
	assign rmse_3 = root[3];

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !$past(fpush) || $past(qfull) || !$past(qpop)) else $error("full");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty) else $error("result lost");
	a_nopop: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !qpop) else $error("queue drained during output");
endmodule

// ===== rtl/vra_front.sv =====
`timescale 1ns / 1ps
module vra_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic signed [vra_pkg::DataW-1:0] est [vra_pkg::Lanes],
	input  logic signed [vra_pkg::DataW-1:0] truth [vra_pkg::Lanes],
	input  logic                             last_pair,
	input  logic                             q_full,
	output logic                             ready,
	output logic                             q_push,
	output vra_pkg::job_t                    q_data
);
	logic [vra_pkg::CntW-1:0] cnt_q;
	logic                     full_cnt;
	logic                     acc;
	logic signed [vra_pkg::DataW:0] d [vra_pkg::Lanes];
	logic [vra_pkg::DataW-1:0] m [vra_pkg::Lanes];

	assign ready = !q_full;
	assign acc = in_valid && ready;
	assign full_cnt = (cnt_q == vra_pkg::CntW'(vra_pkg::MaxSamples));

	always_comb begin
		for (int i = 0; i < vra_pkg::Lanes; i++) begin
			d[i] = {est[i][vra_pkg::DataW-1], est[i]} - {truth[i][vra_pkg::DataW-1], truth[i]};
			m[i] = d[i][vra_pkg::DataW] ? vra_pkg::DataW'(-d[i]) : d[i][vra_pkg::DataW-1:0];
			q_data.sq[i] = vra_pkg::SqW'(m[i]) * vra_pkg::SqW'(m[i]);
		end
		q_data.cnt_en = !full_cnt;
		q_data.last = last_pair;
	end
	assign q_push = acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (acc) begin
			if (last_pair) cnt_q <= '0;
			else if (!full_cnt) cnt_q <= cnt_q + 1'b1;
		end
	end
endmodule

// ===== rtl/vra_queue.sv =====
`timescale 1ns / 1ps
module vra_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  vra_pkg::job_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output vra_pkg::job_t rdata
);
	vra_pkg::job_t mem_q [vra_pkg::QDepth];
	logic wp_q, rp_q;
	logic [1:0] n_q;

	assign full = (n_q == 2'(vra_pkg::QDepth));
	assign empty = (n_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			n_q <= '0;
		end else begin
			if (push && !full) wp_q <= !wp_q;
			if (pop && !empty) rp_q <= !rp_q;
			n_q <= n_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end
endmodule

// ===== rtl/vra_back.sv =====
`timescale 1ns / 1ps
module vra_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  vra_pkg::job_t               q_data,
	output logic                        q_pop,
	output vra_pkg::root_t              root [vra_pkg::Lanes],
	output logic                        ovf,
	output logic                        res_empty,
	input  logic                        res_pop
);
	vra_pkg::sum_t sum_q [vra_pkg::Lanes];
	logic [vra_pkg::CntW-1:0] cnt_q;
	logic sat_q;
	vra_pkg::bk_state_t st_q, st_d;
	logic [5:0] step_q;
	vra_pkg::sum_t rem_q [vra_pkg::Lanes];
	logic [31:0] quo_q [vra_pkg::Lanes];
	logic [33:0] srem_q [vra_pkg::Lanes];
	vra_pkg::root_t root_q [vra_pkg::Lanes];
	logic [33:0] strial [vra_pkg::Lanes];
	logic [33:0] shr [vra_pkg::Lanes];

	assign q_pop = (st_q == vra_pkg::BK_IDLE) && !q_empty;
	assign res_empty = (st_q != vra_pkg::BK_OUT);
	assign root = root_q;
	assign ovf = sat_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			vra_pkg::BK_IDLE: if (q_pop && q_data.last) st_d = vra_pkg::BK_DIV;
			vra_pkg::BK_DIV:  if (step_q == 6'd44) st_d = vra_pkg::BK_SQRT;
			vra_pkg::BK_SQRT: if (step_q == 6'd15) st_d = vra_pkg::BK_OUT;
			vra_pkg::BK_OUT:  if (res_pop) st_d = vra_pkg::BK_IDLE;
			default:          st_d = vra_pkg::BK_IDLE;
		endcase
		for (int i = 0; i < vra_pkg::Lanes; i++) begin
			shr[i] = {srem_q[i][31:0], quo_q[i][31:30]};
			strial[i] = shr[i] - {16'd0, root_q[i], 2'b01};
		end
	end

	// accumulation, long division and bit-serial root; rem_q holds the partial remainder in low CntW+1 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= vra_pkg::BK_IDLE;
			cnt_q <= '0;
			sat_q <= 1'b0;
			step_q <= '0;
			for (int i = 0; i < vra_pkg::Lanes; i++) begin
				sum_q[i] <= '0;
				rem_q[i] <= '0;
				quo_q[i] <= '0;
				srem_q[i] <= '0;
				root_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			unique case (st_q)
				vra_pkg::BK_IDLE: begin
					step_q <= '0;
					if (q_pop) begin
						if (q_data.cnt_en) begin
							cnt_q <= cnt_q + 1'b1;
							for (int i = 0; i < vra_pkg::Lanes; i++)
								sum_q[i] <= sum_q[i] + vra_pkg::SumW'(q_data.sq[i]);
						end else sat_q <= 1'b1;
						for (int i = 0; i < vra_pkg::Lanes; i++) rem_q[i] <= '0;
					end
				end
				vra_pkg::BK_DIV: begin
					step_q <= (step_q == 6'd44) ? 6'd0 : step_q + 1'b1;
					for (int i = 0; i < vra_pkg::Lanes; i++) begin
						logic [vra_pkg::CntW:0] t;
						logic [vra_pkg::CntW:0] r;
						logic qb;
						t = {rem_q[i][vra_pkg::CntW-1:0], sum_q[i][6'd44 - step_q]};
						qb = (cnt_q != '0) && (t >= {1'b0, cnt_q});
						r = qb ? t - {1'b0, cnt_q} : t;
						rem_q[i] <= vra_pkg::SumW'(r);
						quo_q[i] <= {quo_q[i][30:0], qb};
						if (step_q == 6'd44) begin
							srem_q[i] <= '0;
							root_q[i] <= '0;
						end
					end
				end
				vra_pkg::BK_SQRT: begin
					step_q <= step_q + 1'b1;
					for (int i = 0; i < vra_pkg::Lanes; i++) begin
						quo_q[i] <= {quo_q[i][29:0], 2'b00};
						if (!strial[i][33]) begin
							srem_q[i] <= strial[i];
							root_q[i] <= {root_q[i][14:0], 1'b1};
						end else begin
							srem_q[i] <= shr[i];
							root_q[i] <= {root_q[i][14:0], 1'b0};
						end
					end
				end
				vra_pkg::BK_OUT: begin
					step_q <= '0;
					if (res_pop) begin
						cnt_q <= '0;
						sat_q <= 1'b0;
						for (int i = 0; i < vra_pkg::Lanes; i++) sum_q[i] <= '0;
					end
				end
				default: step_q <= '0;
			endcase
		end
	end
endmodule

// ===== tb/sv/vector_rmse_accumulator_core_tb.sv =====
`timescale 1ns / 1ps
module vector_rmse_accumulator_core_tb;

	typedef struct {
		logic signed [15:0] est[vra_pkg::Lanes];
		logic signed [15:0] truth[vra_pkg::Lanes];
		logic               last;
	} pair_t;

	typedef struct {
		logic [15:0] rmse[vra_pkg::Lanes];
		logic        ovf;
	} rmse_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic signed [15:0] est_0, est_1, est_2, est_3;
	logic signed [15:0] truth_0, truth_1, truth_2, truth_3;
	logic last_pair;
	logic empty;
	logic pop;
	logic [15:0] rmse_0, rmse_1, rmse_2, rmse_3;
	logic overflow;

	logic [63:0] lane_sums[vra_pkg::Lanes];
	int unsigned pair_count;
	bit          saturated;
	rmse_t       rmse_queue[$];
	int          fail_count;
	int          send_idle_pct;
	int          pop_stall_pct;
	int          pairs_sent;

	vector_rmse_accumulator_core dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.est_0(est_0), .est_1(est_1), .est_2(est_2), .est_3(est_3),
		.truth_0(truth_0), .truth_1(truth_1), .truth_2(truth_2), .truth_3(truth_3),
		.last_pair(last_pair), .empty(empty), .pop(pop),
		.rmse_0(rmse_0), .rmse_1(rmse_1), .rmse_2(rmse_2), .rmse_3(rmse_3),
		.overflow(overflow)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [15:0] floor_sqrt(logic [31:0] x);
		logic [31:0] root;
		logic [31:0] bitv;
		root = 0;
		bitv = 32'h4000_0000;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= root + bitv) begin
				x = x - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root[15:0];
	endfunction

	task automatic accumulate_pair(pair_t p);
		rmse_t r;
		logic signed [17:0] d;
		logic [63:0] m;
		logic [63:0] mean;
		if (pair_count >= vra_pkg::MaxSamples) begin
			saturated = 1;
		end else begin
			for (int i = 0; i < vra_pkg::Lanes; i++) begin
				d = 18'(p.est[i]) - 18'(p.truth[i]);
				m = d < 0 ? 64'(-d) : 64'(d);
				lane_sums[i] += m * m;
			end
			pair_count++;
		end
		if (p.last) begin
			for (int i = 0; i < vra_pkg::Lanes; i++) begin
				mean = pair_count != 0 ? lane_sums[i] / pair_count : 0;
				if (mean > 64'hFFFF_FFFF)
					mean = 64'hFFFF_FFFF;
				r.rmse[i] = floor_sqrt(mean[31:0]);
				lane_sums[i] = 0;
			end
			r.ovf = saturated;
			rmse_queue.insert(rmse_queue.size(), r);
			pair_count = 0;
			saturated = 0;
		end
	endtask

	task automatic send_pair(pair_t p);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		{est_0, est_1, est_2, est_3} <= {p.est[0], p.est[1], p.est[2], p.est[3]};
		{truth_0, truth_1, truth_2, truth_3} <=
			{p.truth[0], p.truth[1], p.truth[2], p.truth[3]};
		last_pair <= p.last;
		do
			@(posedge clk);
		while (full);
		accumulate_pair(p);
		pairs_sent++;
	endtask

	function automatic pair_t rand_pair(bit last, int mag);
		pair_t p;
		for (int i = 0; i < vra_pkg::Lanes; i++) begin
			case ($urandom_range(3))
				0: begin
					p.est[i] = 16'sh7FFF;
					p.truth[i] = 16'sh8000;
				end
				1: begin
					p.est[i] = 16'sh8000;
					p.truth[i] = 16'sh7FFF;
				end
				default: begin
					p.est[i] = mag == 0 ? 16'($urandom) : 16'($urandom_range(2 * mag) - mag);
					p.truth[i] = mag == 0 ? 16'($urandom) : 16'($urandom_range(2 * mag) - mag);
				end
			endcase
		end
		p.last = last;
		return p;
	endfunction

	task automatic send_set(int len, int mag);
		for (int k = 0; k < len; k++)
			send_pair(rand_pair(k == len - 1, mag));
	endtask

	task automatic drain_results();
		push <= 0;
		while (rmse_queue.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	always @(posedge clk) begin
		rmse_t e;
		logic [15:0] got[vra_pkg::Lanes];
		if (pop && !empty) begin
			got = '{rmse_0, rmse_1, rmse_2, rmse_3};
			if (rmse_queue.size() == 0) begin
				$error("result beat with nothing expected");
				fail_count++;
			end else begin
				e = rmse_queue.pop_front();
				for (int i = 0; i < vra_pkg::Lanes; i++)
					if (got[i] !== e.rmse[i]) begin
						$error("rmse_%0d exp %0d got %0d", i, e.rmse[i], got[i]);
						fail_count++;
					end
				if (overflow !== e.ovf) begin
					$error("overflow exp %0d got %0d", e.ovf, overflow);
					fail_count++;
				end
			end
		end
		pop <= !(pop_stall_pct > 0 && $urandom_range(99) < pop_stall_pct);
	end

	task automatic test_directed();
		pair_t p;
		p = '{est: '{0, 0, 0, 0}, truth: '{0, 0, 0, 0}, last: 1};
		send_pair(p);
		p = '{est: '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh0100},
			truth: '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'shFF00}, last: 1};
		send_pair(p);
		p = '{est: '{16'shFFFF, 16'sh5555, 16'shAAAA, 1},
			truth: '{16'sh0000, 16'shAAAA, 16'sh5555, 0}, last: 0};
		send_pair(p);
		p.last = 1;
		send_pair(p);
		send_set(5, 300);
		send_set(3, 0);
		drain_results();
	endtask

	task automatic test_saturation();
		send_set(vra_pkg::MaxSamples + 3, 0);
		drain_results();
	endtask

	task automatic test_random(int n_pairs);
		int target;
		target = pairs_sent + n_pairs;
		while (pairs_sent < target) begin
			case ($urandom_range(9))
				0: send_set($urandom_range(40, 12), 0);
				1, 2: send_set(1, $urandom_range(4000));
				default: send_set($urandom_range(10, 1), $urandom_range(1, 32767));
			endcase
			if ($urandom_range(19) == 0 && rmse_queue.size() != 0) begin
				push <= 0;
				while (rmse_queue.size() != 0)
					@(posedge clk);
			end
		end
		drain_results();
	endtask

	initial begin
		arst_n = 0;
		push = 0;
		pop = 0;
		last_pair = 0;
		{est_0, est_1, est_2, est_3} = '0;
		{truth_0, truth_1, truth_2, truth_3} = '0;
		fail_count = 0;
		pairs_sent = 0;
		send_idle_pct = 0;
		pop_stall_pct = 0;
		pair_count = 0;
		saturated = 0;
		for (int i = 0; i < vra_pkg::Lanes; i++)
			lane_sums[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(225);
		send_idle_pct = 50;
		test_random(225);
		send_idle_pct = 0;
		pop_stall_pct = 50;
		test_saturation();
		test_random(225);
		send_idle_pct = 36;
		pop_stall_pct = 36;
		test_random(225);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/vra_pkg.sv
rtl/vra_front.sv
rtl/vra_queue.sv
rtl/vra_back.sv
rtl/vector_rmse_accumulator_core.sv
tb/sv/vector_rmse_accumulator_core_tb.sv
